>>> hdl/bstk_pkg.sv
// Package for the bounded stack block: sizes, op and status codes,
// command and result word types, sequencer states.
// No dependencies; imported by bounded_stack_with_positional_ops.
package bstk_pkg;

  // Store depth and derived widths
  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int OCC_W  = 5;
  // Compare width for positions against the count
  localparam int CMP_W  = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  // Op codes
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_PEEK   = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_INSERT = 3'd4;
  localparam logic [2:0] OP_DELETE = 3'd5;
  localparam logic [2:0] OP_MIDDLE = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OVER   = 2'd1;
  localparam logic [1:0] ST_UNDER  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]        position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [WORD_W-1:0] word_a;
    logic signed [WORD_W-1:0] word_b;
    logic                    two_middles;
    logic                    found;
    logic [OCC_W-1:0]        occupancy;
  } result_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_RD,
    SQ_USE,
    SQ_PUT,
    SQ_DONE
  } sq_state_t;

endpackage

>>> hdl/bstk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/bounded_stack_with_positional_ops.sv
// Top level of the bounded stack with positional insert, delete, search and middle.
// Depends on bstk_pkg and bstk_ram.
//
//  channel   ports                    direction  handshake
//  -------   -----------------------  ---------  -----------------------------------
//  command   start, busy, cmd         in         word taken when start && !busy
//  result    done, result             out        one word per command, done for 1 cycle
//
// Steps per command, from its acceptance in IDLE through DONE back to IDLE:
//   push, op 7, any error, insert at top, delete of top: straight to DONE
//   pop, peek, odd middle: one RD/USE pair;  even middle reads both middle words
//   search: one RD/USE pair per word;  insert/delete: one per word moved (+PUT for insert)
// The single-port-read store sets the steps: each moved or compared word passes
// through a read state and a use state. Reset (rst, synchronous) empties the stack;
// store contents are not cleared. Results cannot be stalled.
module bounded_stack_with_positional_ops
  import bstk_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  // Physical layout: address 0 is the bottom word, address count-1 the top.
  // Position p from the top lives at count - p.

  sq_state_t state, state_next;

  logic [2:0]              cur_op, cur_op_next;
  logic signed [WORD_W-1:0] key, key_next;
  logic [CNT_W-1:0]        ptr, ptr_next;
  logic [CNT_W-1:0]        stop, stop_next;
  logic [CNT_W-1:0]        count, count_next;
  logic                    second, second_next;
  logic [1:0]              status, status_next;
  logic signed [WORD_W-1:0] word_a, word_a_next;
  logic signed [WORD_W-1:0] word_b, word_b_next;
  logic                    two_mid, two_mid_next;
  logic                    found, found_next;

  // store port
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;

  // shared address step and compare
  logic [CNT_W-1:0] ptr_inc, ptr_dec;
  logic             hit;

  // command checks
  logic             full, empty, ins_bad, del_bad;
  logic [CMP_W-1:0] pos_x, cnt_x;
  logic [CNT_W-1:0] slot, phys, half, mid_hi, mid_lo;

  bstk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign ptr_inc = ptr + CNT_W'(1);
  assign ptr_dec = ptr - CNT_W'(1);
  assign hit     = ($signed(rdata) == key);

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pos_x   = CMP_W'(cmd.position);
  assign cnt_x   = CMP_W'(count);
  assign ins_bad = (pos_x == '0) || (pos_x > cnt_x + CMP_W'(1));
  assign del_bad = (pos_x == '0) || (pos_x > cnt_x);
  assign slot    = CNT_W'(cnt_x + CMP_W'(1) - pos_x);
  assign phys    = CNT_W'(cnt_x - pos_x);
  assign half    = count >> 1;
  assign mid_hi  = count - half;            // upper middle when count is even
  assign mid_lo  = count - half - CNT_W'(1); // lower middle, or the one middle when odd

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cur_op  <= cur_op_next;
    key     <= key_next;
    ptr     <= ptr_next;
    stop    <= stop_next;
    second  <= second_next;
    status  <= status_next;
    word_a  <= word_a_next;
    word_b  <= word_b_next;
    two_mid <= two_mid_next;
    found   <= found_next;
  end

  always_comb begin
    state_next   = state;
    cur_op_next  = cur_op;
    key_next     = key;
    ptr_next     = ptr;
    stop_next    = stop;
    count_next   = count;
    second_next  = second;
    status_next  = status;
    word_a_next  = word_a;
    word_b_next  = word_b;
    two_mid_next = two_mid;
    found_next   = found;
    we           = 1'b0;
    waddr        = ptr[ADDR_W-1:0];
    wdata        = key;

    unique case (state)
      SQ_IDLE: begin
        if (start) begin
          cur_op_next  = cmd.op;
          key_next     = cmd.value;
          second_next  = 1'b0;
          status_next  = ST_OK;
          word_a_next  = '0;
          word_b_next  = '0;
          two_mid_next = 1'b0;
          found_next   = 1'b0;
          state_next   = SQ_DONE;
          unique case (cmd.op)
            OP_PUSH: begin
              if (full) begin
                status_next = ST_OVER;
              end else begin
                we         = 1'b1;
                waddr      = count[ADDR_W-1:0];
                wdata      = cmd.value;
                count_next = count + CNT_W'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (empty) begin
                status_next = ST_UNDER;
              end else begin
                ptr_next   = count - CNT_W'(1);
                state_next = SQ_RD;
              end
            end
            OP_SEARCH: begin
              if (empty) begin
                status_next = ST_UNDER;
              end else begin
                ptr_next   = '0;
                stop_next  = count - CNT_W'(1);
                state_next = SQ_RD;
              end
            end
            OP_INSERT: begin
              if (full) begin
                status_next = ST_OVER;
              end else if (ins_bad) begin
                status_next = ST_BADPOS;
              end else if (slot == count) begin
                // new top: no words to move
                we         = 1'b1;
                waddr      = count[ADDR_W-1:0];
                wdata      = cmd.value;
                count_next = count + CNT_W'(1);
              end else begin
                ptr_next   = count - CNT_W'(1);
                stop_next  = slot;
                state_next = SQ_RD;
              end
            end
            OP_DELETE: begin
              if (empty) begin
                status_next = ST_UNDER;
              end else if (del_bad) begin
                status_next = ST_BADPOS;
              end else if (phys == count - CNT_W'(1)) begin
                count_next = count - CNT_W'(1);
              end else begin
                ptr_next   = phys + CNT_W'(1);
                stop_next  = count - CNT_W'(1);
                state_next = SQ_RD;
              end
            end
            OP_MIDDLE: begin
              if (empty) begin
                status_next = ST_UNDER;
              end else begin
                ptr_next   = count[0] ? mid_lo : mid_hi;
                state_next = SQ_RD;
              end
            end
            default: begin
              // unused code: empty ok result
            end
          endcase
        end
      end

      SQ_RD: begin
        // read address settles; data ready next cycle
        state_next = SQ_USE;
      end

      SQ_USE: begin
        state_next = SQ_DONE;
        unique case (cur_op)
          OP_POP: begin
            word_a_next = $signed(rdata);
            count_next  = count - CNT_W'(1);
          end
          OP_PEEK: begin
            word_a_next = $signed(rdata);
          end
          OP_SEARCH: begin
            if (hit) begin
              found_next = 1'b1;
            end
            if (ptr != stop) begin
              ptr_next   = ptr_inc;
              state_next = SQ_RD;
            end
          end
          OP_INSERT: begin
            // move one word up, walking down from the top
            we    = 1'b1;
            waddr = ptr_inc[ADDR_W-1:0];
            wdata = rdata;
            if (ptr == stop) begin
              state_next = SQ_PUT;
            end else begin
              ptr_next   = ptr_dec;
              state_next = SQ_RD;
            end
          end
          OP_DELETE: begin
            // move one word down, walking up to the top
            we    = 1'b1;
            waddr = ptr_dec[ADDR_W-1:0];
            wdata = rdata;
            if (ptr == stop) begin
              count_next = count - CNT_W'(1);
            end else begin
              ptr_next   = ptr_inc;
              state_next = SQ_RD;
            end
          end
          OP_MIDDLE: begin
            if (second) begin
              word_b_next = $signed(rdata);
            end else begin
              word_a_next = $signed(rdata);
              if (!count[0]) begin
                two_mid_next = 1'b1;
                second_next  = 1'b1;
                ptr_next     = ptr_dec;
                state_next   = SQ_RD;
              end
            end
          end
          default: begin
          end
        endcase
      end

      SQ_PUT: begin
        we         = 1'b1;
        waddr      = stop[ADDR_W-1:0];
        wdata      = key;
        count_next = count + CNT_W'(1);
        state_next = SQ_DONE;
      end

      SQ_DONE: begin
        state_next = SQ_IDLE;
      end

      default: begin
        state_next = SQ_IDLE;
      end
    endcase
  end

  assign busy = (state != SQ_IDLE);
  assign done = (state == SQ_DONE);

  assign result.status      = status;
  assign result.word_a      = word_a;
  assign result.word_b      = word_b;
  assign result.two_middles = two_mid;
  assign result.found       = found;
  assign result.occupancy   = OCC_W'(count);

endmodule
